// ----- rtl/fixed_point_arith_unit_top_defines.svh -----
// Assertion macros for the fixed-point arithmetic unit.
// Included by the top level; depends on nothing else.
`ifndef FIXED_POINT_ARITH_UNIT_TOP_DEFINES_SVH
`define FIXED_POINT_ARITH_UNIT_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpa check failed");
// Plain condition checked on every clock edge outside reset.
`define FPA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fpa check failed");
`endif

// ----- rtl/fpa_pkg.sv -----
// Shared types and constants for the fixed-point arithmetic unit.
// Used by every module in the rtl folder; depends on nothing.
package fpa_pkg;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W = 64;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0,
    OP_DIV = 3'd1,
    OP_MULDIV = 3'd2,
    OP_INV = 3'd3,
    OP_SQRT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0] op;
    logic qneg;
    logic dzero;
  } ctl_t;
endpackage

// ----- rtl/fpa_prep.sv -----
// Front stages: magnitudes, the 64-bit product, and dividend selection.
// Depends on fpa_pkg.
module fpa_prep (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [2:0] op,
  input  logic signed [31:0] opnd_a,
  input  logic signed [31:0] opnd_b,
  input  logic signed [31:0] opnd_c,
  output logic out_valid,
  output fpa_pkg::ctl_t out_ctl,
  output logic [63:0] num,
  output logic [31:0] den,
  output logic [31:0] raw_a
);
  logic v1;
  logic [2:0] op1;
  logic an1, bn1, cn1;
  logic [31:0] am1, bm1, cm1, a1;
  logic [63:0] prod1;
  logic [31:0] am_c, bm_c, cm_c;
  logic [63:0] mul_r;
  logic [63:0] num_next;
  logic [31:0] den_next;
  logic neg_next;

  assign am_c = opnd_a[31] ? (~opnd_a + 32'd1) : opnd_a;
  assign bm_c = opnd_b[31] ? (~opnd_b + 32'd1) : opnd_b;
  assign cm_c = opnd_c[31] ? (~opnd_c + 32'd1) : opnd_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    op1 <= op;
    an1 <= opnd_a[31];
    bn1 <= opnd_b[31];
    cn1 <= opnd_c[31];
    am1 <= am_c;
    bm1 <= bm_c;
    cm1 <= cm_c;
    a1 <= opnd_a;
    prod1 <= 64'(am_c) * 64'(bm_c);
  end

  always_comb begin
    num_next = 64'd0;
    den_next = 32'd0;
    neg_next = 1'b0;
    mul_r = (an1 != bn1) ? (~prod1 + 64'd1) : prod1;
    case (op1)
      fpa_pkg::OP_MUL: begin
        num_next = (mul_r + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
      end
      fpa_pkg::OP_DIV: begin
        num_next = 64'(am1) << fpa_pkg::FRAC_BITS;
        den_next = bm1;
        neg_next = an1 != bn1;
      end
      fpa_pkg::OP_MULDIV: begin
        num_next = prod1;
        den_next = cm1;
        neg_next = (an1 != bn1) != cn1;
      end
      fpa_pkg::OP_INV: begin
        num_next = 64'd1 << (2 * fpa_pkg::FRAC_BITS);
        den_next = am1;
        neg_next = an1;
      end
      fpa_pkg::OP_SQRT: begin
        num_next = 64'(a1) << fpa_pkg::FRAC_BITS;
      end
      default: begin
        num_next = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_ctl.op <= op1;
    out_ctl.qneg <= neg_next;
    out_ctl.dzero <= (den_next == 32'd0);
    num <= num_next;
    den <= den_next;
    raw_a <= a1;
  end
endmodule

// ----- rtl/fpa_divsq.sv -----
// Unrolled pipeline: one quotient bit per stage; one root bit per stage until the root is full, then it is held.
// Depends on fpa_pkg; stages are registered one after another.
module fpa_divsq (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  fpa_pkg::ctl_t in_ctl,
  input  logic [63:0] num,
  input  logic [31:0] den,
  input  logic [31:0] raw_a,
  output logic out_valid,
  output fpa_pkg::ctl_t out_ctl,
  output logic [63:0] quo,
  output logic [31:0] root,
  output logic [31:0] pass
);
  logic vld [fpa_pkg::NUM_W+1];
  fpa_pkg::ctl_t ctl [fpa_pkg::NUM_W+1];
  logic [63:0] q [fpa_pkg::NUM_W+1];
  logic [32:0] rem [fpa_pkg::NUM_W+1];
  logic [31:0] dv [fpa_pkg::NUM_W+1];
  logic [63:0] sv [fpa_pkg::NUM_W+1];
  logic [33:0] sr [fpa_pkg::NUM_W+1];
  logic [31:0] rt [fpa_pkg::NUM_W+1];
  logic [31:0] av [fpa_pkg::NUM_W+1];

  assign vld[0] = in_valid;
  assign ctl[0] = in_ctl;
  assign q[0] = num;
  assign rem[0] = 33'd0;
  assign dv[0] = den;
  assign sv[0] = {raw_a, 32'd0} >> (32 - fpa_pkg::FRAC_BITS);
  assign sr[0] = 34'd0;
  assign rt[0] = 32'd0;
  assign av[0] = num[31:0];

  for (genvar i = 0; i < fpa_pkg::NUM_W; i++) begin : g_stg
    logic [33:0] r_sh;
    logic [33:0] r_sub;
    logic [35:0] s_sh;
    logic [35:0] s_trial;
    assign r_sh = {rem[i], q[i][63]};
    assign r_sub = r_sh - {2'b00, dv[i]};
    assign s_sh = {sr[i], sv[i][63:62]};
    assign s_trial = {2'b00, rt[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      ctl[i+1] <= ctl[i];
      dv[i+1] <= dv[i];
      av[i+1] <= av[i];
      if (!r_sub[33]) begin
        rem[i+1] <= r_sub[32:0];
        q[i+1] <= {q[i][62:0], 1'b1};
      end else begin
        rem[i+1] <= r_sh[32:0];
        q[i+1] <= {q[i][62:0], 1'b0};
      end
      if (i < 32) begin
        sv[i+1] <= {sv[i][61:0], 2'b00};
        if (s_sh >= s_trial) begin
          sr[i+1] <= 34'(s_sh - s_trial);
          rt[i+1] <= {rt[i][30:0], 1'b1};
        end else begin
          sr[i+1] <= s_sh[33:0];
          rt[i+1] <= {rt[i][30:0], 1'b0};
        end
      end else begin
        sv[i+1] <= sv[i];
        sr[i+1] <= sr[i];
        rt[i+1] <= rt[i];
      end
    end
  end

  assign out_valid = vld[fpa_pkg::NUM_W];
  assign out_ctl = ctl[fpa_pkg::NUM_W];
  assign quo = q[fpa_pkg::NUM_W];
  assign root = rt[fpa_pkg::NUM_W];
  assign pass = av[fpa_pkg::NUM_W];
endmodule

// ----- rtl/fixed_point_arith_unit_top.sv -----
// Channel   Signals                              Direction
// request   start, busy, op, opnd_a/b/c          in (busy: out)
// result    done, result, status                 out
// Each request passes 67 register stages: two prep stages, 64 division stages
// (one quotient bit per stage) and one output stage, which registers done.
// A request can be accepted in every cycle; busy is held low outside reset.
// Synchronous reset (rst) clears all valid bits and drops requests in flight.
// Top level of the fixed-point arithmetic unit.
// Depends on fpa_pkg, fpa_prep, fpa_divsq and the defines header.
`include "fixed_point_arith_unit_top_defines.svh"
module fixed_point_arith_unit_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [2:0] op,
  input  logic signed [31:0] opnd_a,
  input  logic signed [31:0] opnd_b,
  input  logic signed [31:0] opnd_c,
  output logic done,
  output logic signed [31:0] result,
  output logic [1:0] status
);
  logic p_valid, d_valid;
  fpa_pkg::ctl_t p_ctl, d_ctl;
  logic [63:0] p_num, d_quo;
  logic [31:0] d_pass;
  logic [31:0] p_den, p_a, d_root;
  logic [31:0] res_next;
  logic [1:0] st_next;
  logic ovf;

  assign busy = rst;

  fpa_prep u_prep (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .op(op),
    .opnd_a(opnd_a), .opnd_b(opnd_b), .opnd_c(opnd_c),
    .out_valid(p_valid), .out_ctl(p_ctl), .num(p_num), .den(p_den), .raw_a(p_a)
  );

  fpa_divsq u_divsq (
    .clk(clk), .rst(rst), .in_valid(p_valid), .in_ctl(p_ctl), .num(p_num),
    .den(p_den), .raw_a(p_a), .out_valid(d_valid), .out_ctl(d_ctl),
    .quo(d_quo), .root(d_root), .pass(d_pass)
  );

  always_comb begin
    res_next = 32'd0;
    st_next = fpa_pkg::ST_OK;
    ovf = d_ctl.qneg && (d_quo != 64'd0) ? (d_quo > 64'h80000000)
                                         : (d_quo > 64'h7FFFFFFF);
    case (d_ctl.op)
      fpa_pkg::OP_MUL: begin
        res_next = d_pass;
      end
      fpa_pkg::OP_DIV, fpa_pkg::OP_MULDIV, fpa_pkg::OP_INV: begin
        if (d_ctl.dzero) begin
          st_next = fpa_pkg::ST_DIV0;
        end else if (ovf) begin
          st_next = fpa_pkg::ST_OVF;
        end else if (d_ctl.qneg) begin
          res_next = ~d_quo[31:0] + 32'd1;
        end else begin
          res_next = d_quo[31:0];
        end
      end
      fpa_pkg::OP_SQRT: begin
        res_next = d_root;
      end
      default: begin
        res_next = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
    result <= res_next;
    status <= st_next;
  end

  `FPA_ASSERT_ALWAYS(a_status_code, status != 2'd3 || !done)
  `FPA_ASSERT_IMPL(a_done_follows, d_valid, ##1 done)
  `FPA_ASSERT_IMPL(a_div0_zero, done && status == fpa_pkg::ST_DIV0, result == 32'd0)
endmodule
